// ----- rtl/jse_pkg.sv -----
package jse_pkg;

   // Request kinds carried on the input tuser.
   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_BYTE  = 2'd1;
   localparam logic [1:0] REQ_END   = 2'd2;

   // Default number of jobs held between the front and the back.
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Characters used by the escaper.
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U = 8'h75;

   // One classified request: up to two u escapes, then an optional
   // tail character that may carry a backslash in front of it.
   typedef struct packed {
      logic [1:0]  n_units;
      logic [15:0] unit0;
      logic [15:0] unit1;
      logic        tail_en;
      logic        pre_esc;
      logic [7:0]  tail_char;
      logic        done;
   } jse_job_type;

   // Lowercase hex digit for a nibble.
   function automatic logic [7:0] hex_char(input logic [3:0] v);
      logic [7:0] r;
      if (v < 4'd10) begin
         r = 8'h30 + {4'd0, v};
      end else begin
         r = 8'h57 + {4'd0, v};
      end
      return r;
   endfunction

endpackage

// ----- rtl/jse_front.sv -----
module jse_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                escape_utf8,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [1:0]          req_type,
   input  logic [7:0]          byte_value,
   input  logic                queue_full,
   output logic                push,
   output jse_pkg::jse_job_type push_job
);
   import jse_pkg::*;

   logic [20:0] pending_code_ff, pending_code_in;
   logic [1:0]  bytes_left_ff, bytes_left_in;
   logic        accept;
   logic        has_job;
   logic [20:0] cont_code;
   jse_job_type job;

   // Fill in the u escape units for a code point, splitting into a
   // surrogate pair above the basic plane.
   function automatic jse_job_type code_units(input jse_job_type base,
                                              input logic [20:0] cp);
      jse_job_type j;
      logic [20:0] v;
      j = base;
      v = cp - 21'h10000;
      if (cp[20:16] == 5'd0) begin
         j.n_units = 2'd1;
         j.unit0   = cp[15:0];
      end else begin
         j.n_units = 2'd2;
         j.unit0   = 16'hD800 | {5'd0, v[20:10]};
         j.unit1   = 16'hDC00 | {6'd0, v[9:0]};
      end
      return j;
   endfunction

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign cont_code  = {pending_code_ff[14:0], byte_value[5:0]};

   // Classify the request and work out the decoder state that follows it.
   always_comb begin
      job             = '0;
      has_job         = 1'b0;
      pending_code_in = pending_code_ff;
      bytes_left_in   = bytes_left_ff;
      unique case (req_type)
         REQ_START: begin
            has_job         = 1'b1;
            job.tail_en     = 1'b1;
            job.tail_char   = CH_QUOTE;
            pending_code_in = '0;
            bytes_left_in   = '0;
         end
         REQ_BYTE: begin
            if (bytes_left_ff != 2'd0) begin
               pending_code_in = cont_code;
               bytes_left_in   = bytes_left_ff - 2'd1;
               if (bytes_left_ff == 2'd1) begin
                  has_job         = 1'b1;
                  job             = code_units(job, cont_code);
                  pending_code_in = '0;
               end
            end else begin
               has_job = 1'b1;
               unique case (byte_value)
                  8'h22: begin job.tail_en = 1'b1; job.pre_esc = 1'b1; job.tail_char = 8'h22; end
                  8'h5C: begin job.tail_en = 1'b1; job.pre_esc = 1'b1; job.tail_char = 8'h5C; end
                  8'h08: begin job.tail_en = 1'b1; job.pre_esc = 1'b1; job.tail_char = 8'h62; end
                  8'h0C: begin job.tail_en = 1'b1; job.pre_esc = 1'b1; job.tail_char = 8'h66; end
                  8'h0A: begin job.tail_en = 1'b1; job.pre_esc = 1'b1; job.tail_char = 8'h6E; end
                  8'h0D: begin job.tail_en = 1'b1; job.pre_esc = 1'b1; job.tail_char = 8'h72; end
                  8'h09: begin job.tail_en = 1'b1; job.pre_esc = 1'b1; job.tail_char = 8'h74; end
                  default: begin
                     if (byte_value < 8'h20) begin
                        job.n_units = 2'd1;
                        job.unit0   = {8'd0, byte_value};
                     end else if (escape_utf8 && byte_value[7]) begin
                        // A lead byte opens a sequence and emits nothing yet.
                        has_job = 1'b0;
                        if (byte_value < 8'hE0) begin
                           pending_code_in = {16'd0, byte_value[4:0]};
                           bytes_left_in   = 2'd1;
                        end else if (byte_value < 8'hF0) begin
                           pending_code_in = {17'd0, byte_value[3:0]};
                           bytes_left_in   = 2'd2;
                        end else begin
                           pending_code_in = {18'd0, byte_value[2:0]};
                           bytes_left_in   = 2'd3;
                        end
                     end else begin
                        job.tail_en   = 1'b1;
                        job.tail_char = byte_value;
                     end
                  end
               endcase
            end
         end
         REQ_END: begin
            // Flush a sequence cut short, then close the string.
            has_job = 1'b1;
            if (bytes_left_ff != 2'd0) begin
               job = code_units(job, pending_code_ff);
            end
            job.tail_en     = 1'b1;
            job.tail_char   = CH_QUOTE;
            job.done        = 1'b1;
            pending_code_in = '0;
            bytes_left_in   = '0;
         end
         default: begin
            has_job = 1'b0;
         end
      endcase
   end

   assign push     = accept && has_job;
   assign push_job = job;

   // Decoder state advances only on an accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_code_ff <= '0;
         bytes_left_ff   <= '0;
      end else if (accept) begin
         pending_code_ff <= pending_code_in;
         bytes_left_ff   <= bytes_left_in;
      end
   end

endmodule

// ----- rtl/jse_queue.sv -----
module jse_queue #(
   parameter int DEPTH = 2   // power of two, at least 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  jse_pkg::jse_job_type push_job,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output jse_pkg::jse_job_type head_job
);
   import jse_pkg::*;

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   jse_job_type            slots_ff [DEPTH];
   logic [PtrW-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]        count_ff, count_in;

   assign full      = (count_ff == CntW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_job  = slots_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/jse_back.sv -----
module jse_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   input  jse_pkg::jse_job_type job,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           out_char,
   output logic                 run_last,
   output logic                 string_done
);
   import jse_pkg::*;

   localparam logic [1:0] PH_UNIT = 2'd0;
   localparam logic [1:0] PH_PRE  = 2'd1;
   localparam logic [1:0] PH_TAIL = 2'd2;

   logic       first_ff;
   logic [1:0] phase_ff;
   logic       uidx_ff;
   logic [2:0] dig_ff;
   logic [1:0] cur_phase, next_phase;
   logic       cur_uidx, next_uidx;
   logic [2:0] cur_dig, next_dig;
   logic       advance, last_char;
   logic [15:0] unit;
   logic [3:0]  nib;
   logic [7:0]  ch;
   logic        rsp_tvalid_ff;
   logic [7:0]  out_char_ff;
   logic        run_last_ff, string_done_ff;

   // Position within the current job; a fresh job starts at its first phase.
   always_comb begin
      if (first_ff) begin
         cur_uidx = 1'b0;
         cur_dig  = 3'd0;
         if (job.n_units != 2'd0) begin
            cur_phase = PH_UNIT;
         end else if (job.pre_esc) begin
            cur_phase = PH_PRE;
         end else begin
            cur_phase = PH_TAIL;
         end
      end else begin
         cur_phase = phase_ff;
         cur_uidx  = uidx_ff;
         cur_dig   = dig_ff;
      end
   end

   // Character at the current position.
   always_comb begin
      unit = cur_uidx ? job.unit1 : job.unit0;
      unique case (cur_dig)
         3'd2:    nib = unit[15:12];
         3'd3:    nib = unit[11:8];
         3'd4:    nib = unit[7:4];
         default: nib = unit[3:0];
      endcase
      unique case (cur_phase)
         PH_UNIT: begin
            if (cur_dig == 3'd0) begin
               ch = CH_BSLASH;
            end else if (cur_dig == 3'd1) begin
               ch = CH_U;
            end else begin
               ch = hex_char(nib);
            end
         end
         PH_PRE:  ch = CH_BSLASH;
         default: ch = job.tail_char;
      endcase
   end

   // Step to the next position, or mark the job finished.
   always_comb begin
      next_phase = cur_phase;
      next_uidx  = cur_uidx;
      next_dig   = cur_dig;
      last_char  = 1'b0;
      unique case (cur_phase)
         PH_UNIT: begin
            if (cur_dig != 3'd5) begin
               next_dig = cur_dig + 3'd1;
            end else if (!cur_uidx && job.n_units == 2'd2) begin
               next_uidx = 1'b1;
               next_dig  = 3'd0;
            end else if (job.tail_en) begin
               next_phase = job.pre_esc ? PH_PRE : PH_TAIL;
            end else begin
               last_char = 1'b1;
            end
         end
         PH_PRE:  next_phase = PH_TAIL;
         default: last_char = 1'b1;
      endcase
   end

   assign advance = job_valid && (!rsp_tvalid_ff || rsp_tready);
   assign pop     = advance && last_char;

   // Sequencer position.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
         phase_ff <= PH_UNIT;
         uidx_ff  <= 1'b0;
         dig_ff   <= 3'd0;
      end else if (advance) begin
         first_ff <= last_char;
         phase_ff <= next_phase;
         uidx_ff  <= next_uidx;
         dig_ff   <= next_dig;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (advance) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_char_ff    <= ch;
         run_last_ff    <= last_char;
         string_done_ff <= last_char && job.done;
      end
   end

   assign rsp_tvalid  = rsp_tvalid_ff;
   assign out_char    = out_char_ff;
   assign run_last    = run_last_ff;
   assign string_done = string_done_ff;

   // The closing quote ends its request.
   a_done_is_quote: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && string_done_ff |-> run_last_ff && out_char_ff == CH_QUOTE)
      else $error("closing quote malformed");

   // A job is retired only while one is present.
   a_pop_needs_job: assert property (@(posedge clock) disable iff (reset)
      pop |-> job_valid)
      else $error("pop without a job");

   // The digit counter never runs past the last hex digit.
   a_dig_range: assert property (@(posedge clock) disable iff (reset)
      !first_ff |-> dig_ff <= 3'd5)
      else $error("digit counter out of range");

endmodule

// ----- rtl/json_string_escaper_unit.sv -----
// The first character of a request reaches rsp via the job queue and then the
// back output register. Throughput: one character per cycle while rsp_tready
// allows, set by the back sequencer; a request holds it for each character it
// expands into. The front accepts until the job queue (QUEUE_DEPTH jobs) fills.
// Reset (synchronous, active high) clears the UTF-8 escape mode, the UTF-8
// decoder state, the job queue and the output register.
module json_string_escaper_unit #(
   parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] byte_value
   input  logic [1:0] req_tuser,    // [1:0] req_type
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_char
   output logic       rsp_tlast,
   output logic       rsp_tuser     // [0] string_done
);
   import jse_pkg::*;

   logic        escape_utf8_ff;
   logic        queue_full, queue_not_empty;
   logic        push, pop;
   jse_job_type push_job, head_job;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         escape_utf8_ff <= 1'b0;
      end else if (csr_wr_en) begin
         escape_utf8_ff <= csr_wr_data;
      end
   end

   jse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .escape_utf8 (escape_utf8_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_type    (req_tuser),
      .byte_value  (req_tdata),
      .queue_full  (queue_full),
      .push        (push),
      .push_job    (push_job)
   );

   jse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_job  (head_job)
   );

   jse_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (queue_not_empty),
      .job         (head_job),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .out_char    (rsp_tdata),
      .run_last    (rsp_tlast),
      .string_done (rsp_tuser)
   );

endmodule
